### rtl/mzc_pkg.sv
// Shared types and constants for the mains zero-cross calibrator.
// No dependencies; every other file of the block imports this package.
package mzc_pkg;

    localparam int TIME_W  = 32;
    localparam int US_W    = 26;
    localparam int RETRY_W = 8;
    localparam int PHASE_W = 3;
    localparam int REQ_W   = 2;
    localparam int CFG_IDX_W = 3;

    // pipeline depth of the divide-by-ticks unit
    localparam int DIV_LAT = 3;

    typedef logic [REQ_W-1:0]   req_t;
    typedef logic [PHASE_W-1:0] phase_t;

    localparam req_t REQ_EDGE  = 2'd0;
    localparam req_t REQ_START = 2'd1;
    localparam req_t REQ_IDLE  = 2'd2;

    localparam phase_t PH_IDLE   = 3'd0;
    localparam phase_t PH_START  = 3'd1;
    localparam phase_t PH_FIRST  = 3'd2;
    localparam phase_t PH_SECOND = 3'd3;
    localparam phase_t PH_DONE   = 3'd4;

    localparam logic [CFG_IDX_W-1:0] CFG_MIN_GAP   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PULSE_MIN = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PULSE_MAX = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_HALF_MIN  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_HALF_MAX  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_RETRY_LIM = 3'd5;

    localparam logic [US_W-1:0]    RST_MIN_GAP   = 26'd5000;
    localparam logic [US_W-1:0]    RST_PULSE_MIN = 26'd200;
    localparam logic [US_W-1:0]    RST_PULSE_MAX = 26'd1000;
    localparam logic [US_W-1:0]    RST_HALF_MIN  = 26'd5000;
    localparam logic [US_W-1:0]    RST_HALF_MAX  = 26'd12000;
    localparam logic [RETRY_W-1:0] RST_RETRY_LIM = 8'd10;

    typedef struct packed {
        logic [US_W-1:0]    min_gap;
        logic [US_W-1:0]    pulse_min;
        logic [US_W-1:0]    pulse_max;
        logic [US_W-1:0]    half_min;
        logic [US_W-1:0]    half_max;
        logic [RETRY_W-1:0] retry_limit;
    } mzc_cfg_t;

    // request as taken in, plus the timestamp of the edge before it
    typedef struct packed {
        req_t              req;
        logic [TIME_W-1:0] t;
        logic              fall;
        logic [TIME_W-1:0] prev;
    } mzc_raw_t;

    // classified request, as queued for the back end
    typedef struct packed {
        mzc_raw_t        raw;
        logic [US_W-1:0] gap_us;
        logic            gap_ok;
    } mzc_item_t;

    typedef struct packed {
        logic full;
        logic valid;
    } mzc_qstat_t;

    // packs into the result word with detector_disable in bit 0
    typedef struct packed {
        logic [RETRY_W-1:0] retries;
        logic [US_W-1:0]    half_wave_us;
        logic [US_W-1:0]    pulse_width_us;
        phase_t             phase_code;
        logic               detector_disable;
    } mzc_result_t;

endpackage

### rtl/mzc_div.sv
// Pipelined divide of a 32-bit tick count by TICKS_PER_US, saturated to 26 bits.
// Reciprocal multiply, remainder correction; uses mzc_pkg.
module mzc_div #(
    parameter int TICKS_PER_US = 80
) (
    input  logic                      aclk,
    input  logic                      en,
    input  logic [mzc_pkg::TIME_W-1:0] x,
    output logic [mzc_pkg::US_W-1:0]   q
);
    import mzc_pkg::*;

    localparam int KW    = $clog2(TICKS_PER_US + 1);
    localparam int REM_W = $clog2(2 * TICKS_PER_US) + 1;
    localparam int PW    = 2 * TIME_W + 1;
    localparam logic [TIME_W:0]    RECIP = (TIME_W + 1)'((PW'(1) << TIME_W) / TICKS_PER_US);
    localparam logic [KW-1:0]      K_MUL = KW'(TICKS_PER_US);
    localparam logic [REM_W-1:0]   K_REM = REM_W'(TICKS_PER_US);

    logic [PW-1:0]          prod;
    logic [TIME_W+KW-1:0]   qk;
    logic [TIME_W-1:0]      rem;
    logic [TIME_W:0]        q_inc;
    logic [US_W-1:0]        q_next;

    logic [TIME_W-1:0]      x1_reg;
    logic [TIME_W-1:0]      q1_reg;
    logic [TIME_W-1:0]      q2_reg;
    logic [REM_W-1:0]       r2_reg;
    logic [US_W-1:0]        q_reg;

    // estimate is exact or one short
    assign prod  = PW'(x) * PW'(RECIP);
    assign qk    = (TIME_W + KW)'(q1_reg) * (TIME_W + KW)'(K_MUL);
    assign rem   = x1_reg - qk[TIME_W-1:0];
    assign q_inc = {1'b0, q2_reg} + (TIME_W + 1)'(r2_reg >= K_REM);

    always_comb begin
        if (|q_inc[TIME_W:US_W]) begin
            q_next = '1;
        end else begin
            q_next = q_inc[US_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            x1_reg <= x;
            q1_reg <= prod[2*TIME_W-1:TIME_W];
            q2_reg <= q1_reg;
            r2_reg <= rem[REM_W-1:0];
            q_reg  <= q_next;
        end
    end

    assign q = q_reg;

endmodule

### rtl/mzc_fifo.sv
// Short queue of classified requests between front and back end.
// Uses mzc_pkg for the entry and status types.
module mzc_fifo #(
    parameter int DEPTH = 4
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                push,
    input  mzc_pkg::mzc_item_t  wr_item,
    input  logic                pop,
    output mzc_pkg::mzc_item_t  rd_item,
    output mzc_pkg::mzc_qstat_t stat
);
    import mzc_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL = CW'(DEPTH);

    mzc_item_t      mem_reg [DEPTH];
    logic [AW-1:0]  wr_ptr_reg;
    logic [AW-1:0]  rd_ptr_reg;
    logic [CW-1:0]  count_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == LAST) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == LAST) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= wr_item;
        end
    end

    assign rd_item    = mem_reg[rd_ptr_reg];
    assign stat.valid = (count_reg != '0);
    assign stat.full  = (count_reg == FULL);

endmodule

### rtl/mzc_front.sv
// Front end: take requests, track the last edge time, divide the edge gap to us.
// Uses mzc_pkg and mzc_div.
module mzc_front #(
    parameter int TICKS_PER_US = 80
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [2:0]                  s_tuser,
    input  logic [mzc_pkg::TIME_W-1:0]  s_tdata,
    input  logic [mzc_pkg::US_W-1:0]    min_gap,
    input  logic                        q_full,
    output logic                        push,
    output mzc_pkg::mzc_item_t          item
);
    import mzc_pkg::*;

    localparam int STAGES = DIV_LAT + 1;

    logic                 en;
    logic                 accept;
    mzc_raw_t             raw_in;
    logic [US_W-1:0]      gap_us;

    logic [TIME_W-1:0]    prev_reg;
    logic [TIME_W-1:0]    diff_reg;
    mzc_raw_t             pipe_reg [STAGES];
    logic [STAGES-1:0]    valid_reg;

    // stall everything only when the last stage cannot drain
    assign en       = !(valid_reg[STAGES-1] && q_full);
    assign s_tready = en;
    assign accept   = s_tvalid && en;

    assign raw_in.req  = s_tuser[1:0];
    assign raw_in.fall = s_tuser[2];
    assign raw_in.t    = s_tdata;
    assign raw_in.prev = prev_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_reg  <= '0;
            valid_reg <= '0;
        end else begin
            if (accept && raw_in.req == REQ_EDGE) begin
                prev_reg <= s_tdata;
            end
            if (en) begin
                valid_reg <= {valid_reg[STAGES-2:0], s_tvalid};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            diff_reg    <= s_tdata - prev_reg;
            pipe_reg[0] <= raw_in;
            for (int i = 1; i < STAGES; i++) begin
                pipe_reg[i] <= pipe_reg[i-1];
            end
        end
    end

    mzc_div #(
        .TICKS_PER_US(TICKS_PER_US)
    ) u_div (
        .aclk (aclk),
        .en   (en),
        .x    (diff_reg),
        .q    (gap_us)
    );

    assign push        = valid_reg[STAGES-1] && en;
    assign item.raw    = pipe_reg[STAGES-1];
    assign item.gap_us = gap_us;
    assign item.gap_ok = gap_us > min_gap;

endmodule

### rtl/mzc_back.sv
// Back end: calibration phase logic, pulse measurement and the result register.
// Uses mzc_pkg and one mzc_div for the pulse width.
module mzc_back #(
    parameter int TICKS_PER_US = 80
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  mzc_pkg::mzc_cfg_t          cfg,
    input  mzc_pkg::mzc_item_t         head,
    input  logic                       head_valid,
    output logic                       pop,
    output logic                       m_tvalid,
    input  logic                       m_tready,
    output mzc_pkg::mzc_result_t       m_tdata
);
    import mzc_pkg::*;

    localparam int MEAS_LAT = DIV_LAT + 1;
    localparam int MCW      = $clog2(MEAS_LAT + 1);
    localparam logic [MCW-1:0] MEAS_DONE = MCW'(MEAS_LAT);

    phase_t               phase_reg,  phase_next;
    logic [TIME_W-1:0]    mark_reg,   mark_next;
    logic [US_W-1:0]      pw_reg,     pw_next;
    logic [US_W-1:0]      hw_reg,     hw_next;
    logic [RETRY_W-1:0]   retry_reg,  retry_next;
    logic [MCW-1:0]       meas_cnt_reg;
    logic [TIME_W-1:0]    meas_x_reg;
    logic                 m_valid_reg;
    mzc_result_t          m_data_reg;

    logic                 out_free;
    logic                 late_fall;
    logic                 needs_meas;
    logic                 meas_ready;
    logic                 fire;
    logic                 in_range;
    logic                 disable_next;
    logic [TIME_W-1:0]    span_mark;
    logic [US_W-1:0]      pulse_us;

    assign out_free  = !m_valid_reg || m_tready;
    assign span_mark = head.raw.t - mark_reg;
    assign late_fall = head.raw.fall && (phase_reg == PH_IDLE)
                       && (span_mark > TIME_W'(pw_reg >> 1));

    // a counted rising edge in the second half needs the pulse width first
    assign needs_meas = head_valid && (head.raw.req == REQ_EDGE)
                        && (phase_reg == PH_SECOND) && !head.raw.fall && head.gap_ok;
    assign meas_ready = (meas_cnt_reg == MEAS_DONE);
    assign fire       = head_valid && out_free && (!needs_meas || meas_ready);
    assign pop        = fire;

    mzc_div #(
        .TICKS_PER_US(TICKS_PER_US)
    ) u_div (
        .aclk (aclk),
        .en   (1'b1),
        .x    (meas_x_reg),
        .q    (pulse_us)
    );

    assign in_range = (pulse_us > cfg.pulse_min) && (pulse_us < cfg.pulse_max)
                      && (head.gap_us > cfg.half_min) && (head.gap_us < cfg.half_max);

    always_comb begin
        phase_next   = phase_reg;
        mark_next    = mark_reg;
        pw_next      = pw_reg;
        hw_next      = hw_reg;
        retry_next   = retry_reg;
        disable_next = 1'b0;
        case (head.raw.req)
            REQ_START: begin
                phase_next = PH_START;
            end
            REQ_IDLE: begin
                phase_next = PH_IDLE;
            end
            REQ_EDGE: begin
                if (late_fall) begin
                    disable_next = 1'b1;
                end else if (phase_reg == PH_START) begin
                    phase_next = PH_FIRST;
                    mark_next  = '0;
                    pw_next    = '0;
                    hw_next    = '0;
                end else if (!head.raw.fall && head.gap_ok) begin
                    case (phase_reg)
                        PH_FIRST: begin
                            phase_next = PH_SECOND;
                            mark_next  = head.raw.t;
                        end
                        PH_SECOND: begin
                            pw_next = pulse_us;
                            hw_next = head.gap_us;
                            if (retry_reg > cfg.retry_limit || in_range) begin
                                phase_next = PH_DONE;
                            end else begin
                                phase_next = PH_START;
                                if (retry_reg != '1) begin
                                    retry_next = retry_reg + 1'b1;
                                end
                            end
                        end
                        PH_DONE: begin
                            mark_next  = head.raw.t;
                            retry_next = '0;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg    <= PH_IDLE;
            mark_reg     <= '0;
            pw_reg       <= '0;
            hw_reg       <= '0;
            retry_reg    <= '0;
            meas_cnt_reg <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (fire) begin
                phase_reg    <= phase_next;
                mark_reg     <= mark_next;
                pw_reg       <= pw_next;
                hw_reg       <= hw_next;
                retry_reg    <= retry_next;
                meas_cnt_reg <= '0;
                m_valid_reg  <= 1'b1;
            end else begin
                if (needs_meas && !meas_ready) begin
                    meas_cnt_reg <= meas_cnt_reg + 1'b1;
                end
                if (m_tready) begin
                    m_valid_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        meas_x_reg <= head.raw.prev - mark_reg;
        if (fire) begin
            m_data_reg.detector_disable <= disable_next;
            m_data_reg.phase_code       <= phase_next;
            m_data_reg.pulse_width_us   <= pw_next;
            m_data_reg.half_wave_us     <= hw_next;
            m_data_reg.retries          <= retry_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule

### rtl/mains_zero_cross_calibrator.sv
// Top level of the mains zero-cross calibrator: configuration registers,
// front end, request queue and back end. Uses mzc_pkg and all mzc_* modules.
//
// Usage
//   s_* : request stream. s_tuser[1:0] request kind (edge, start, idle),
//         s_tuser[2] falling edge flag, s_tdata the 32-bit capture time in ticks.
//   m_* : one result word per request, in request order.
//   cfg_* : register writes, always ready; write only while no request is in
//         flight. Indexes past the last register are dropped.
// Throughput and path
//   One request per cycle while s_tready is high. A result passes through the
//   front-end pipeline, the queue and the back end's output register. A rising
//   edge that closes a measurement holds the back end while its pulse-width
//   divider runs; the queue keeps taking requests meanwhile until it fills.
// Stall
//   A stalled result holds in the output register; the back end and then the
//   queue and front end back up behind it, and s_tready drops once the front
//   end's last stage cannot drain.
// Reset
//   aresetn low clears phase to idle, timestamps and measurements to zero,
//   empties the queue and loads the register defaults.
module mains_zero_cross_calibrator #(
    parameter int TICKS_PER_US = 80,
    parameter int QUEUE_DEPTH  = 4
) (
    input  logic        aclk,
    input  logic        aresetn,
    // request stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [2:0]  s_tuser,   // [1:0] req_type, [2] falling
    input  logic [31:0] s_tdata,   // [31:0] capture_time
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    // [0] detector_disable, [3:1] phase_code, [29:4] pulse_width_us,
    // [55:30] half_wave_us, [63:56] retries
    output logic [63:0] m_tdata,
    // configuration writes
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [25:0] cfg_data
);
    import mzc_pkg::*;

    mzc_cfg_t    cfg_reg;
    mzc_item_t   q_wr_item;
    mzc_item_t   q_rd_item;
    mzc_qstat_t  q_stat;
    mzc_result_t res_view;
    logic        q_push;
    logic        q_pop;

    // configuration: take every write, drop unknown indexes
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.min_gap     <= RST_MIN_GAP;
            cfg_reg.pulse_min   <= RST_PULSE_MIN;
            cfg_reg.pulse_max   <= RST_PULSE_MAX;
            cfg_reg.half_min    <= RST_HALF_MIN;
            cfg_reg.half_max    <= RST_HALF_MAX;
            cfg_reg.retry_limit <= RST_RETRY_LIM;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                CFG_MIN_GAP:   cfg_reg.min_gap     <= cfg_data;
                CFG_PULSE_MIN: cfg_reg.pulse_min   <= cfg_data;
                CFG_PULSE_MAX: cfg_reg.pulse_max   <= cfg_data;
                CFG_HALF_MIN:  cfg_reg.half_min    <= cfg_data;
                CFG_HALF_MAX:  cfg_reg.half_max    <= cfg_data;
                CFG_RETRY_LIM: cfg_reg.retry_limit <= cfg_data[RETRY_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // front end: classify and time-convert the edge gap
    mzc_front #(
        .TICKS_PER_US(TICKS_PER_US)
    ) u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tuser  (s_tuser),
        .s_tdata  (s_tdata),
        .min_gap  (cfg_reg.min_gap),
        .q_full   (q_stat.full),
        .push     (q_push),
        .item     (q_wr_item)
    );

    // decouple front and back
    mzc_fifo #(
        .DEPTH(QUEUE_DEPTH)
    ) u_fifo (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (q_push),
        .wr_item (q_wr_item),
        .pop     (q_pop),
        .rd_item (q_rd_item),
        .stat    (q_stat)
    );

    // back end: phase sequencing, measurement, result register
    mzc_back #(
        .TICKS_PER_US(TICKS_PER_US)
    ) u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg_reg),
        .head       (q_rd_item),
        .head_valid (q_stat.valid),
        .pop        (q_pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (res_view)
    );

    assign m_tdata = res_view;

    // detector disable only ever comes out of an idle calibration
    a_disable_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && res_view.detector_disable |-> res_view.phase_code == PH_IDLE)
        else $error("detector disable raised outside idle phase");

    // measurements stay cleared from the start edge until the measuring edge
    a_meas_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (res_view.phase_code == PH_FIRST || res_view.phase_code == PH_SECOND)
        |-> res_view.pulse_width_us == '0 && res_view.half_wave_us == '0)
        else $error("stale measurement during a half-wave phase");

    // the front end never pushes into a full queue
    a_no_overrun: assert property (@(posedge aclk) disable iff (!aresetn)
        !(q_push && q_stat.full))
        else $error("push into full request queue");

    // input back-pressure only comes from a full queue
    a_stall_src: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> q_stat.full)
        else $error("input stalled while the queue has room");

endmodule

### tb/tb_mains_zero_cross_calibrator.sv
// Self-checking testbench for mains_zero_cross_calibrator: request words go in,
// result words are predicted in the bench and compared field by field.
// Depends on mzc_pkg and the block's RTL; needs nothing else.
module tb_mains_zero_cross_calibrator;
    timeunit 1ns;
    timeprecision 1ps;

    import mzc_pkg::*;

    localparam int          TICKS_PER_US     = 80;
    localparam int unsigned CYCLE_LIMIT      = 1_000_000;
    localparam int unsigned RX_HOLD_CYCLES   = 300;
    localparam int unsigned END_DRAIN_CYCLES = 20;
    localparam int unsigned MAX_PRINTS       = 40;

    // request code that the block must ignore
    localparam req_t REQ_UNUSED = 2'd3;
    // register index past the last register; the block drops such writes
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE = 3'd7;

    // ------------------------------------------------------------------
    // clock, reset and block ports
    // ------------------------------------------------------------------
    logic aclk    = 1'b0;
    logic aresetn = 1'b0;

    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [2:0]  s_tuser   = '0;   // [1:0] req_type, [2] falling
    logic [31:0] s_tdata   = '0;   // [31:0] capture_time

    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    // [0] detector_disable, [3:1] phase_code, [29:4] pulse_width_us,
    // [55:30] half_wave_us, [63:56] retries
    logic [63:0] m_tdata;

    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [25:0]          cfg_data  = '0;

    always #6 aclk = ~aclk;

    mains_zero_cross_calibrator #(
        .TICKS_PER_US(TICKS_PER_US)
    ) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tuser  (s_tuser),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    // ------------------------------------------------------------------
    // calibrator state as the bench tracks it
    // ------------------------------------------------------------------
    mzc_cfg_t           cfg_shadow;
    phase_t             cal_phase;
    logic [TIME_W-1:0]  mark_t;
    logic [TIME_W-1:0]  prev_t;
    logic [US_W-1:0]    pulse_us;
    logic [US_W-1:0]    half_us;
    logic [RETRY_W-1:0] retry_cnt;

    // result words still owed by the block, oldest first
    mzc_result_t results_due[$];

    // running capture timestamp for generated edges; wraps freely
    logic [TIME_W-1:0] tick_now;

    // traffic shaping: steady means no idle cycles on that side
    bit tx_steady   = 1'b0;
    bit rx_steady   = 1'b0;
    bit rx_hold_req = 1'b0;

    int unsigned cycle_count      = 0;
    int unsigned items_sent       = 0;
    int unsigned results_checked  = 0;
    int unsigned error_count      = 0;
    int unsigned settings_loaded  = 0;
    int unsigned calib_done_count = 0;
    int unsigned retry_events     = 0;
    int unsigned disable_count    = 0;

    // ------------------------------------------------------------------
    // helpers
    // ------------------------------------------------------------------

    // Idle length for either side: mostly none or short, now and then long.
    function automatic int unsigned idle_len();
        int unsigned roll = $urandom_range(0, 99);
        if (roll < 55) return 0;
        if (roll < 85) return $urandom_range(1, 3);
        if (roll < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 90);
    endfunction

    // Capture ticks to microseconds, saturating at the 26-bit ceiling.
    function automatic logic [US_W-1:0] ticks_to_us(logic [TIME_W-1:0] ticks);
        logic [TIME_W-1:0] q;
        q = ticks / TICKS_PER_US;
        if (q > {{(TIME_W-US_W){1'b0}}, {US_W{1'b1}}}) return {US_W{1'b1}};
        return q[US_W-1:0];
    endfunction

    // Microseconds to ticks; jitter adds a random fraction of a microsecond.
    function automatic logic [TIME_W-1:0] us_ticks(int unsigned us, bit jitter);
        longint unsigned v;
        v = longint'(us) * TICKS_PER_US;
        if (jitter) v += $urandom_range(0, TICKS_PER_US - 1);
        return v[TIME_W-1:0];
    endfunction

    // Pulse width for a generated measurement: mostly inside the window,
    // else a boundary or a value anywhere.
    function automatic int unsigned pick_pulse();
        int unsigned lo = cfg_shadow.pulse_min + 1;
        int unsigned hi = cfg_shadow.pulse_max;
        if (hi > lo && $urandom_range(0, 9) < 7) return $urandom_range(lo, hi - 1);
        case ($urandom_range(0, 3))
            0:       return cfg_shadow.pulse_min;
            1:       return cfg_shadow.pulse_max;
            2:       return $urandom_range(0, 3000);
            default: return $urandom & 32'h03FF_FFFF;
        endcase
    endfunction

    // Half-wave length: the closing edge must also clear the edge gap.
    function automatic int unsigned pick_half();
        int unsigned lo = cfg_shadow.half_min + 1;
        int unsigned hi = cfg_shadow.half_max;
        if (cfg_shadow.min_gap + 1 > lo) lo = cfg_shadow.min_gap + 1;
        if (hi > lo && $urandom_range(0, 9) < 7) return $urandom_range(lo, hi - 1);
        case ($urandom_range(0, 3))
            0:       return cfg_shadow.half_min;
            1:       return cfg_shadow.half_max;
            2:       return $urandom_range(0, 20000);
            default: return $urandom & 32'h03FF_FFFF;
        endcase
    endfunction

    // One request word through the calibrator: update the tracked state and
    // queue the result word it must produce.
    task automatic calib_step(input req_t req, input logic [TIME_W-1:0] t,
                              input logic fall);
        mzc_result_t       r;
        logic [US_W-1:0]   gap_us;
        logic [TIME_W-1:0] since_mark;
        logic              in_window;
        r = '0;
        case (req)
            REQ_START: cal_phase = PH_START;
            REQ_IDLE:  cal_phase = PH_IDLE;
            REQ_EDGE: begin
                gap_us     = ticks_to_us(t - prev_t);
                since_mark = t - mark_t;
                // ticks since the mark against half the pulse width in us, as is
                if (fall && cal_phase == PH_IDLE &&
                        since_mark > TIME_W'(pulse_us >> 1)) begin
                    r.detector_disable = 1'b1;
                    disable_count++;
                end else if (cal_phase == PH_START) begin
                    cal_phase = PH_FIRST;
                    mark_t    = '0;
                    pulse_us  = '0;
                    half_us   = '0;
                end else if (!fall && gap_us > cfg_shadow.min_gap) begin
                    case (cal_phase)
                        PH_FIRST: begin
                            cal_phase = PH_SECOND;
                            mark_t    = t;
                        end
                        PH_SECOND: begin
                            pulse_us  = ticks_to_us(prev_t - mark_t);
                            half_us   = ticks_to_us(t - prev_t);
                            in_window = pulse_us > cfg_shadow.pulse_min &&
                                        pulse_us < cfg_shadow.pulse_max &&
                                        half_us > cfg_shadow.half_min &&
                                        half_us < cfg_shadow.half_max;
                            if (retry_cnt > cfg_shadow.retry_limit || in_window) begin
                                cal_phase = PH_DONE;
                                calib_done_count++;
                            end else begin
                                cal_phase = PH_START;
                                if (retry_cnt != {RETRY_W{1'b1}}) retry_cnt++;
                                retry_events++;
                            end
                        end
                        PH_DONE: begin
                            mark_t    = t;
                            retry_cnt = '0;
                        end
                        default: ;
                    endcase
                end
                prev_t = t;
            end
            default: ;
        endcase
        r.phase_code     = cal_phase;
        r.pulse_width_us = pulse_us;
        r.half_wave_us   = half_us;
        r.retries        = retry_cnt;
        results_due.push_back(r);
    endtask

    task automatic report_mismatch(input string field_name, input logic [63:0] got_v,
                                   input logic [63:0] want_v);
        if (error_count < MAX_PRINTS)
            $display("[%0t] mismatch on %s in result %0d: got %0h, want %0h",
                     $realtime, field_name, results_checked, got_v, want_v);
        error_count++;
    endtask

    // ------------------------------------------------------------------
    // request side
    // ------------------------------------------------------------------

    // Offer one request word and hold it until the block takes it. Valid
    // stays high after the handshake so back-to-back words need no bubble.
    task automatic send_word(input req_t req, input logic [TIME_W-1:0] t,
                             input logic fall);
        int unsigned gap;
        gap = tx_steady ? 0 : idle_len();
        if (gap != 0) begin
            // drop valid and put junk on the idle bus
            s_tvalid <= 1'b0;
            s_tuser  <= 3'($urandom);
            s_tdata  <= $urandom;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= {fall, req};
        s_tdata  <= t;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        items_sent++;
        calib_step(req, t, fall);
    endtask

    // Stop offering and wait until every owed result word is back.
    task automatic settle_results();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (results_due.size() != 0);
    endtask

    // Write every register, plus one write to an unused index that must be
    // dropped. Only called with the block idle.
    task automatic load_regs(input mzc_cfg_t c);
        logic [CFG_IDX_W-1:0] idx [7];
        logic [25:0]          val [7];
        logic [25:0]          junk;
        settle_results();
        junk = 26'($urandom);
        idx = '{CFG_MIN_GAP, CFG_PULSE_MIN, CFG_PULSE_MAX, CFG_HALF_MIN,
                CFG_HALF_MAX, CFG_RETRY_LIM, CFG_IDX_SPARE};
        // upper bits of the retry limit write are don't-care for the block
        val = '{c.min_gap, c.pulse_min, c.pulse_max, c.half_min, c.half_max,
                {junk[25:8], c.retry_limit}, 26'($urandom)};
        for (int i = 0; i < 7; i++) begin
            cfg_valid <= 1'b1;
            cfg_index <= idx[i];
            cfg_data  <= val[i];
            @(posedge aclk);
            while (!cfg_ready) @(posedge aclk);
            case (idx[i])
                CFG_MIN_GAP:   cfg_shadow.min_gap     = val[i];
                CFG_PULSE_MIN: cfg_shadow.pulse_min   = val[i];
                CFG_PULSE_MAX: cfg_shadow.pulse_max   = val[i];
                CFG_HALF_MIN:  cfg_shadow.half_min    = val[i];
                CFG_HALF_MAX:  cfg_shadow.half_max    = val[i];
                CFG_RETRY_LIM: cfg_shadow.retry_limit = val[i][RETRY_W-1:0];
                default: ;
            endcase
        end
        cfg_valid <= 1'b0;
        settings_loaded++;
    endtask

    // One well-formed calibration: start, arming edge, then marking rising
    // edge, falling edge, closing rising edge, retried while the result falls
    // outside the windows. Usually finish with an idle command and late or early
    // falling edges against the mark.
    task automatic calibrate_once();
        int attempts;
        attempts = 0;
        send_word(REQ_START, $urandom, 1'($urandom));
        do begin
            if (cal_phase == PH_START) begin
                tick_now += $urandom_range(0, 4000);
                send_word(REQ_EDGE, tick_now, 1'($urandom));
            end
            tick_now += us_ticks(cfg_shadow.min_gap + 1 + $urandom_range(0, 200), 1'b1);
            send_word(REQ_EDGE, tick_now, 1'b0);
            tick_now += us_ticks(pick_pulse(), 1'b1);
            send_word(REQ_EDGE, tick_now, 1'b1);
            if ($urandom_range(0, 4) == 0) begin
                // contact chatter well inside the edge gap
                tick_now += $urandom_range(0, 800);
                send_word(REQ_EDGE, tick_now, 1'($urandom));
            end
            tick_now += us_ticks(pick_half(), 1'b1);
            send_word(REQ_EDGE, tick_now, 1'b0);
            attempts++;
        end while (cal_phase == PH_START && attempts < 8);
        if (cal_phase == PH_DONE && $urandom_range(0, 1) == 1) begin
            // a fresh rising edge after finishing re-marks and clears retries
            tick_now += us_ticks(cfg_shadow.min_gap + 1 + $urandom_range(0, 200), 1'b1);
            send_word(REQ_EDGE, tick_now, 1'b0);
        end
        if ($urandom_range(0, 9) < 7) begin
            send_word(REQ_IDLE, $urandom, 1'($urandom));
            repeat ($urandom_range(1, 3))
                send_word(REQ_EDGE, mark_t + $urandom_range(0, pulse_us), 1'b1);
        end
    endtask

    // Mostly calibrations with random content, the rest stray edges,
    // commands and fully random words.
    task automatic run_traffic(input int unsigned n);
        int unsigned target;
        int unsigned roll;
        target = items_sent + n;
        while (items_sent < target) begin
            roll = $urandom_range(0, 99);
            if (roll < 65) begin
                calibrate_once();
            end else if (roll < 80) begin
                if ($urandom_range(0, 3) == 0) tick_now = $urandom;
                else tick_now += $urandom_range(0, 2_000_000);
                send_word(REQ_EDGE, tick_now, 1'($urandom));
            end else if (roll < 92) begin
                case ($urandom_range(0, 2))
                    0:       send_word(REQ_START, $urandom, 1'($urandom));
                    1:       send_word(REQ_IDLE, $urandom, 1'($urandom));
                    default: send_word(REQ_UNUSED, $urandom, 1'($urandom));
                endcase
            end else begin
                send_word(req_t'($urandom_range(0, 3)), $urandom, 1'($urandom));
            end
        end
    endtask

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // Hand-picked words at the reset register values: idle edges, the ignored
    // request code, window boundaries and a measurement across the 32-bit wrap.
    task automatic test_directed_cases();
        logic [TIME_W-1:0] t;
        // late falling edge in idle at the top of the time range
        send_word(REQ_EDGE, 32'hFFFF_FFFF, 1'b1);
        // falling edge right on the mark is not late
        send_word(REQ_EDGE, 32'h0000_0000, 1'b1);
        // rising edge in idle only moves the previous-edge time
        send_word(REQ_EDGE, 32'h0010_0000, 1'b0);
        send_word(REQ_UNUSED, 32'hFFFF_FFFF, 1'b1);
        send_word(REQ_START, 32'hFFFF_FFFF, 1'b1);
        // start the measurement just below the wrap
        t = 32'hFFF0_0000;
        send_word(REQ_EDGE, t, 1'b1);
        t += us_ticks(5000, 1'b0);              // gap equal to the minimum: no count
        send_word(REQ_EDGE, t, 1'b0);
        t += us_ticks(5001, 1'b0);              // marks the pulse
        send_word(REQ_EDGE, t, 1'b0);
        t += us_ticks(500, 1'b0);
        send_word(REQ_EDGE, t, 1'b1);
        t += us_ticks(10000, 1'b0);             // crosses the wrap, inside both windows
        send_word(REQ_EDGE, t, 1'b0);
        t += us_ticks(6000, 1'b0);              // re-mark in finished
        send_word(REQ_EDGE, t, 1'b0);
        send_word(REQ_IDLE, 32'h0000_0000, 1'b0);
        // half of a 500 us pulse is 250, compared against ticks
        send_word(REQ_EDGE, t + 10, 1'b1);
        send_word(REQ_EDGE, t + 251, 1'b1);
        send_word(REQ_EDGE, t + 250, 1'b1);
        // pulse width equal to the maximum fails and counts a retry
        send_word(REQ_START, 32'h5555_5555, 1'b0);
        t += us_ticks(1, 1'b0);
        send_word(REQ_EDGE, t, 1'b0);
        t += us_ticks(6000, 1'b0);
        send_word(REQ_EDGE, t, 1'b0);
        t += us_ticks(1000, 1'b0);
        send_word(REQ_EDGE, t, 1'b1);
        t += us_ticks(8000, 1'b0);
        send_word(REQ_EDGE, t, 1'b0);
        // half wave equal to the maximum fails too
        send_word(REQ_EDGE, t + 7, 1'b1);
        t += us_ticks(6000, 1'b0);
        send_word(REQ_EDGE, t, 1'b0);
        t += us_ticks(300, 1'b0);
        send_word(REQ_EDGE, t, 1'b1);
        t += us_ticks(12000, 1'b0);
        send_word(REQ_EDGE, t, 1'b0);
        send_word(REQ_IDLE, 32'hAAAA_AAAA, 1'b1);
        settle_results();
    endtask

    // All registers at zero, then the 26-bit ones at their top values and the retry limit at 254.
    task automatic test_register_extremes();
        mzc_cfg_t c;
        c = '0;
        load_regs(c);
        run_traffic(100);
        c.min_gap     = '1;
        c.pulse_min   = '1;
        c.pulse_max   = '1;
        c.half_min    = '1;
        c.half_max    = '1;
        c.retry_limit = 8'd254;
        load_regs(c);
        run_traffic(100);
        settle_results();
    endtask

    // An empty pulse window with a retry limit of 254 piles up retries;
    // a zero limit accepts after the first retry.
    task automatic test_retry_limits();
        mzc_cfg_t c;
        c.min_gap     = 26'd3000;
        c.pulse_min   = 26'd500;
        c.pulse_max   = 26'd500;
        c.half_min    = 26'd4000;
        c.half_max    = 26'd15000;
        c.retry_limit = 8'd254;
        load_regs(c);
        run_traffic(130);
        c.pulse_min   = 26'd200;
        c.pulse_max   = 26'd1000;
        c.retry_limit = 8'd0;
        load_regs(c);
        run_traffic(110);
        settle_results();
    endtask

    // Hold the result side off for a long stretch while words keep coming,
    // so the queue fills and s_tready drops; pause until all are back, then send more and settle again.
    task automatic test_backpressure();
        tx_steady   = 1'b1;
        rx_hold_req = 1'b1;
        run_traffic(60);
        tx_steady = 1'b0;
        settle_results();
        run_traffic(30);
        settle_results();
    endtask

    // Random register settings, with stretches of steady traffic on either side.
    task automatic test_random_settings();
        mzc_cfg_t c;
        for (int round = 0; round < 6; round++) begin
            if (round == 5) begin
                c = mzc_cfg_t'({$urandom, $urandom, $urandom, $urandom, $urandom});
                if (c.retry_limit == 8'hFF) c.retry_limit = 8'd254;
            end else begin
                c.min_gap     = $urandom_range(100, 8000);
                c.pulse_min   = $urandom_range(0, 500);
                c.pulse_max   = c.pulse_min + $urandom_range(0, 1500);
                c.half_min    = $urandom_range(1000, 8000);
                c.half_max    = c.half_min + $urandom_range(0, 8000);
                c.retry_limit = $urandom_range(0, 30);
            end
            load_regs(c);
            tx_steady = ($urandom_range(0, 3) == 0);
            rx_steady = ($urandom_range(0, 3) == 0);
            run_traffic(90);
        end
        tx_steady = 1'b0;
        rx_steady = 1'b0;
        settle_results();
    endtask

    // ------------------------------------------------------------------
    // result side
    // ------------------------------------------------------------------

    // Ready pattern: short bursts with stalls between, a long hold on
    // request, no stalls while rx_steady is set. One assignment per edge.
    int unsigned rx_left = 0;
    bit          rx_on   = 1'b0;
    always @(posedge aclk) begin
        if (rx_hold_req) begin
            rx_hold_req = 1'b0;
            rx_on       = 1'b0;
            rx_left     = RX_HOLD_CYCLES;
        end else if (rx_left > 0) begin
            rx_left--;
        end else if (rx_on && !rx_steady) begin
            rx_on   = 1'b0;
            rx_left = idle_len();
        end else begin
            rx_on   = 1'b1;
            rx_left = $urandom_range(0, 12);
        end
        m_tready <= rx_on;
    end

    // Compare every taken result word against the oldest one owed.
    always @(posedge aclk) begin : result_check
        mzc_result_t got;
        mzc_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got = m_tdata;
            if (results_due.size() == 0) begin
                report_mismatch("unexpected result word", got, '0);
            end else begin
                want = results_due.pop_front();
                if (got.detector_disable !== want.detector_disable)
                    report_mismatch("detector_disable", got.detector_disable,
                                    want.detector_disable);
                if (got.phase_code !== want.phase_code)
                    report_mismatch("phase_code", got.phase_code, want.phase_code);
                if (got.pulse_width_us !== want.pulse_width_us)
                    report_mismatch("pulse_width_us", got.pulse_width_us,
                                    want.pulse_width_us);
                if (got.half_wave_us !== want.half_wave_us)
                    report_mismatch("half_wave_us", got.half_wave_us, want.half_wave_us);
                if (got.retries !== want.retries)
                    report_mismatch("retries", got.retries, want.retries);
            end
            results_checked++;
        end
    end

    // Cycle budget for the whole run.
    initial begin : watchdog
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("[%0t] timeout after %0d cycles, %0d result words still owed",
                 $realtime, cycle_count, results_due.size());
        $display("tb_mains_zero_cross_calibrator failed");
        $finish;
    end

    // ------------------------------------------------------------------
    // sequence
    // ------------------------------------------------------------------
    initial begin : main_sequence
        cfg_shadow.min_gap     = RST_MIN_GAP;
        cfg_shadow.pulse_min   = RST_PULSE_MIN;
        cfg_shadow.pulse_max   = RST_PULSE_MAX;
        cfg_shadow.half_min    = RST_HALF_MIN;
        cfg_shadow.half_max    = RST_HALF_MAX;
        cfg_shadow.retry_limit = RST_RETRY_LIM;
        cal_phase = PH_IDLE;
        mark_t    = '0;
        prev_t    = '0;
        pulse_us  = '0;
        half_us   = '0;
        retry_cnt = '0;
        tick_now  = $urandom;

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        test_directed_cases();
        test_register_extremes();
        test_retry_limits();
        test_backpressure();
        test_random_settings();

        // let any stray word show up before the verdict
        settle_results();
        repeat (END_DRAIN_CYCLES) @(posedge aclk);

        $display("Ran %0d request words and checked %0d result words over %0d register loads.",
                 items_sent, results_checked, settings_loaded);
        $display("Saw %0d finished calibrations, %0d retries and %0d detector disables.",
                 calib_done_count, retry_events, disable_count);
        if (error_count == 0) begin
            $display("tb_mains_zero_cross_calibrator passed");
        end else begin
            $display("%0d mismatches", error_count);
            $display("tb_mains_zero_cross_calibrator failed");
        end
        $finish;
    end

endmodule
